// ----- hdl/iltf_pkg.sv -----
// Shared types and constants of the incremental line track fit unit.
`default_nettype none
package iltf_pkg;

    localparam int unsigned WEIGHT_W     = 24;
    localparam logic [23:0] WEIGHT_RESET = 24'd65536;
    // |den| below this raw Q.32 magnitude counts as degenerate
    localparam int unsigned DEN_EPS_RAW  = 5;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_QUERY  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_DEGEN  = 2'd1,
        STAT_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
    } t_in_item;

    typedef struct packed {
        logic        [47:0] hit_chi2;
        logic signed [31:0] slope_x_out;
        logic signed [31:0] offset_x_out;
        logic signed [31:0] slope_y_out;
        logic signed [31:0] offset_y_out;
        logic        [5:0]  count_out;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic        sgn;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [127:0] den;
    } t_div_req;

endpackage
`default_nettype wire

// ----- hdl/iltf_mul.sv -----
// Multi-cycle 64 x 64 multiplier built on one 32 x 32 partial-product unit.
`default_nettype none
module iltf_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire iltf_pkg::t_mul_req i_req,
    output logic                   o_done,
    output logic [127:0]           o_prod
);
    import iltf_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_DONE} t_mstate;

    t_mstate      r_state;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [2:0]   r_cnt;
    logic [63:0]  r_pp;
    logic [1:0]   r_psel;
    logic [127:0] r_acc;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  n_pp;
    logic [127:0] pp_shift;
    logic         a_neg;
    logic         b_neg;

    assign a_neg  = i_req.sgn & i_req.a[63];
    assign b_neg  = i_req.sgn & i_req.b[63];
    assign a_part = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
    assign b_part = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
    assign n_pp   = 64'(a_part) * 64'(b_part);

    always_comb begin
        case (r_psel)
            2'd0:    pp_shift = {64'd0, r_pp};
            2'd3:    pp_shift = {r_pp, 64'd0};
            default: pp_shift = {32'd0, r_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_ua    <= a_neg ? (~i_req.a + 64'd1) : i_req.a;
                        r_ub    <= b_neg ? (~i_req.b + 64'd1) : i_req.b;
                        r_neg   <= a_neg ^ b_neg;
                        r_acc   <= '0;
                        r_cnt   <= 3'd0;
                        r_state <= M_RUN;
                    end
                end
                M_RUN: begin
                    if (!r_cnt[2]) begin
                        r_pp   <= n_pp;
                        r_psel <= r_cnt[1:0];
                    end
                    if (r_cnt != 3'd0) r_acc <= r_acc + pp_shift;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) r_state <= M_DONE;
                end
                M_DONE: r_state <= M_IDLE;
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == M_DONE);
    assign o_prod = r_neg ? (~r_acc + 128'd1) : r_acc;

endmodule
`default_nettype wire

// ----- hdl/iltf_div.sv -----
// Restoring divider: signed 128-bit ratio to Q16.16, saturated to 32 bits.
`default_nettype none
module iltf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire iltf_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [31:0]            o_quo
);
    import iltf_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} t_dstate;

    t_dstate      r_state;
    logic [143:0] r_rem;
    logic [159:0] r_dsh;
    logic [32:0]  r_q;
    logic [5:0]   r_cnt;
    logic         r_neg;

    logic [127:0] abs_num;
    logic [127:0] abs_den;
    logic         ge;
    logic         sat;

    assign abs_num = i_req.num[127] ? (~i_req.num + 128'd1) : i_req.num;
    assign abs_den = i_req.den[127] ? (~i_req.den + 128'd1) : i_req.den;
    assign ge      = ({16'd0, r_rem} >= r_dsh);
    assign sat     = r_q[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_rem   <= {abs_num, 16'd0};
                        r_dsh   <= {abs_den, 32'd0};
                        r_neg   <= i_req.num[127] ^ i_req.den[127];
                        r_q     <= '0;
                        r_cnt   <= 6'd0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // first bit set means the quotient reaches 2^32: saturate
                    if (ge) r_rem <= r_rem - r_dsh[143:0];
                    r_dsh <= r_dsh >> 1;
                    r_q   <= {r_q[31:0], ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) r_state <= D_DONE;
                end
                D_DONE: r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quo = (sat || (r_q[31:0] > 32'h8000_0000)) ? 32'h8000_0000
                                                         : (~r_q[31:0] + 32'd1);
        end else begin
            o_quo = (sat || r_q[31]) ? 32'h7FFF_FFFF : r_q[31:0];
        end
    end

    assign o_done = (r_state == D_DONE);

endmodule
`default_nettype wire

// ----- hdl/incremental_line_track_fit_unit.sv -----
// Top level of the incremental weighted straight-line track fit unit.
// Use:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one hit beat
//   with its operation: start, add, remove or query. Output channel
//   (o_out_valid / i_out_stall / o_out_data) returns one result beat per hit:
//   chi2 against the line held before the hit, the fit after it, the count
//   and a status. i_cfg_we / i_cfg_wdata write the common hit weight.
// Timing:
//   One hit at a time through a shared 64 x 64 multiplier (four 32 x 32
//   partial products) and a 33-step restoring divider. A hit without a solve
//   takes 12 products; a hit that solves takes 22 products and four
//   divisions.
//   o_in_stall is high while a hit is in work.
// Stall:
//   A finished result sits in the output register; the next hit is taken
//   meanwhile and completes once that register has been emptied.
// Reset:
//   Sums, count and fit clear to zero, weight returns to 1.0; no beat is
//   presented until a hit has been accepted.
`default_nettype none
module incremental_line_track_fit_unit #(
    parameter int HIT_LIMIT = 63
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire iltf_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output iltf_pkg::t_out_item     o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_wdata
);
    import iltf_pkg::*;

    localparam int CW = $clog2(HIT_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_UPD, S_DSTART, S_DWAIT, S_DONE
    } t_state;

    // product schedule: chi2, hit terms, then the solve
    typedef enum logic [4:0] {
        P_RX, P_RY, P_EX, P_EY, P_CL, P_CH,
        P_TX, P_TY, P_TZ, P_TXZ, P_TYZ, P_TZZ,
        P_D1, P_D2, P_N1A, P_N1B, P_N2A, P_N2B, P_N3A, P_N3B, P_N4A, P_N4B
    } t_step;

    t_state       r_state;
    t_step        r_step;
    t_in_item     r_item;
    logic [23:0]  r_weight;
    logic [63:0]  r_s0, r_sx, r_sy, r_sz, r_sxz, r_syz, r_szz;
    logic [CW-1:0] r_count;
    logic [31:0]  r_fsx, r_fox, r_fsy, r_foy;
    logic [63:0]  r_dx, r_dy;
    logic [63:0]  r_tx, r_ty, r_tz, r_txz, r_tyz, r_tzz;
    logic [127:0] r_e, r_c, r_p1, r_num, r_den;
    logic         r_degen;
    logic         r_reject;
    logic         r_ovalid;
    t_out_item    r_out;

    t_mul_req     mul_req;
    logic         mul_done;
    logic [127:0] mul_prod;
    t_div_req     div_req;
    logic         div_done;
    logic [31:0]  div_quo;

    logic [63:0]  x64, y64, z64, w64;
    logic [63:0]  n_resid, n_dabs;
    logic [127:0] n_diff, n_dabs128;
    logic         n_small;
    logic         n_reject;
    logic         n_solve;
    logic         in_acc;
    logic         out_acc;
    logic         res_load;
    logic         n_chi_sat;
    logic [CW+5:0] cnt_ext;

    assign x64 = {{32{r_item.hit_x[31]}}, r_item.hit_x};
    assign y64 = {{32{r_item.hit_y[31]}}, r_item.hit_y};
    assign z64 = {{32{r_item.hit_z[31]}}, r_item.hit_z};
    assign w64 = {40'd0, r_weight};

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_ovalid && !i_out_stall;
    // load the output register once the result is ready and the slot is free
    assign res_load   = (r_state == S_DONE) && (!r_ovalid || out_acc);

    // operand selection for the shared multiplier
    always_comb begin
        mul_req.start = (r_state == S_ISSUE);
        mul_req.sgn   = 1'b1;
        case (r_step)
            P_RX:  begin mul_req.a = {{32{r_fsx[31]}}, r_fsx}; mul_req.b = z64; end
            P_RY:  begin mul_req.a = {{32{r_fsy[31]}}, r_fsy}; mul_req.b = z64; end
            P_EX:  begin mul_req.a = r_dx; mul_req.b = r_dx; mul_req.sgn = 1'b0; end
            P_EY:  begin mul_req.a = r_dy; mul_req.b = r_dy; mul_req.sgn = 1'b0; end
            P_CL:  begin mul_req.a = r_e[63:0]; mul_req.b = w64; mul_req.sgn = 1'b0; end
            P_CH:  begin mul_req.a = r_e[127:64]; mul_req.b = w64; mul_req.sgn = 1'b0; end
            P_TX:  begin mul_req.a = w64; mul_req.b = x64; end
            P_TY:  begin mul_req.a = w64; mul_req.b = y64; end
            P_TZ:  begin mul_req.a = w64; mul_req.b = z64; end
            P_TXZ: begin mul_req.a = r_tz; mul_req.b = x64; end
            P_TYZ: begin mul_req.a = r_tz; mul_req.b = y64; end
            P_TZZ: begin mul_req.a = r_tz; mul_req.b = z64; end
            P_D1:  begin mul_req.a = r_szz; mul_req.b = r_s0; end
            P_D2:  begin mul_req.a = r_sz;  mul_req.b = r_sz; end
            P_N1A: begin mul_req.a = r_sxz; mul_req.b = r_s0; end
            P_N1B: begin mul_req.a = r_sx;  mul_req.b = r_sz; end
            P_N2A: begin mul_req.a = r_sx;  mul_req.b = r_szz; end
            P_N2B: begin mul_req.a = r_sxz; mul_req.b = r_sz; end
            P_N3A: begin mul_req.a = r_syz; mul_req.b = r_s0; end
            P_N3B: begin mul_req.a = r_sy;  mul_req.b = r_sz; end
            P_N4A: begin mul_req.a = r_sy;  mul_req.b = r_szz; end
            P_N4B: begin mul_req.a = r_syz; mul_req.b = r_sz; end
            default: begin mul_req.a = '0; mul_req.b = '0; end
        endcase
    end

    assign div_req.start = (r_state == S_DSTART);
    assign div_req.num   = r_num;
    assign div_req.den   = r_den;

    iltf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    iltf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // residual of the held line at hit z, and its magnitude
    always_comb begin
        if (r_step == P_RX) begin
            n_resid = mul_prod[79:16] + {{32{r_fox[31]}}, r_fox} - x64;
        end else begin
            n_resid = mul_prod[79:16] + {{32{r_foy[31]}}, r_foy} - y64;
        end
        n_dabs    = n_resid[63] ? (~n_resid + 64'd1) : n_resid;
        n_diff    = r_p1 - mul_prod;
        n_dabs128 = n_diff[127] ? (~n_diff + 128'd1) : n_diff;
        n_small   = (n_dabs128 < 128'(DEN_EPS_RAW));
    end

    assign n_reject = ((r_item.func == FUNC_ADD) && (r_count >= CW'(HIT_LIMIT))) ||
                      ((r_item.func == FUNC_REMOVE) && (r_count == '0));
    // solve only when the operation goes through and more than one hit stays
    assign n_solve  = !n_reject &&
                      (((r_item.func == FUNC_ADD) && (r_count >= CW'(1))) ||
                       ((r_item.func == FUNC_REMOVE) && (r_count >= CW'(3))));
    assign n_chi_sat = |r_c[127:80];
    assign cnt_ext   = {6'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= P_RX;
            r_weight <= WEIGHT_RESET;
            r_s0     <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sz     <= '0;
            r_sxz    <= '0;
            r_syz    <= '0;
            r_szz    <= '0;
            r_count  <= '0;
            r_fsx    <= '0;
            r_fox    <= '0;
            r_fsy    <= '0;
            r_foy    <= '0;
            r_degen  <= 1'b0;
            r_reject <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_weight <= i_cfg_wdata;
            if (res_load) r_ovalid <= 1'b1;
            else if (out_acc) r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item   <= i_in_data;
                        r_degen  <= 1'b0;
                        r_reject <= 1'b0;
                        r_step   <= P_RX;
                        r_state  <= S_ISSUE;
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (mul_done) begin
                        case (r_step)
                            P_RX:  r_dx <= n_dabs;
                            P_RY:  r_dy <= n_dabs;
                            P_EX:  r_e  <= mul_prod;
                            P_EY:  r_e  <= r_e + mul_prod;
                            P_CL:  r_c  <= mul_prod;
                            P_CH:  r_c  <= {r_c[127:64] + mul_prod[63:0], r_c[63:0]};
                            P_TX:  r_tx  <= mul_prod[79:16];
                            P_TY:  r_ty  <= mul_prod[79:16];
                            P_TZ:  r_tz  <= mul_prod[79:16];
                            P_TXZ: r_txz <= mul_prod[79:16];
                            P_TYZ: r_tyz <= mul_prod[79:16];
                            P_TZZ: r_tzz <= mul_prod[79:16];
                            P_D2: begin
                                // degenerate: take den as 1.0 in Q.32
                                if (n_small) begin
                                    r_den   <= 128'd1 << 32;
                                    r_degen <= 1'b1;
                                end else begin
                                    r_den <= n_diff;
                                end
                            end
                            P_N1B, P_N2B, P_N3B, P_N4B: r_num <= n_diff;
                            default: r_p1 <= mul_prod;
                        endcase
                        if (r_step == P_TZZ) begin
                            r_state <= S_UPD;
                        end else if (r_step inside {P_N1B, P_N2B, P_N3B, P_N4B}) begin
                            r_state <= S_DSTART;
                        end else begin
                            r_step  <= t_step'(r_step + 5'd1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_UPD: begin
                    // apply the operation; solve only when more than one hit stays
                    r_state <= n_solve ? S_ISSUE : S_DONE;
                    r_step  <= P_D1;
                    if (n_reject) begin
                        r_reject <= 1'b1;
                    end else begin
                        case (r_item.func)
                            FUNC_START: begin
                                r_s0 <= w64;   r_sx <= r_tx;   r_sy <= r_ty;
                                r_sz <= r_tz;  r_sxz <= r_txz; r_syz <= r_tyz;
                                r_szz <= r_tzz;
                                r_count <= CW'(1);
                            end
                            FUNC_ADD: begin
                                r_s0 <= r_s0 + w64;     r_sx <= r_sx + r_tx;
                                r_sy <= r_sy + r_ty;    r_sz <= r_sz + r_tz;
                                r_sxz <= r_sxz + r_txz; r_syz <= r_syz + r_tyz;
                                r_szz <= r_szz + r_tzz;
                                r_count <= r_count + CW'(1);
                            end
                            FUNC_REMOVE: begin
                                r_s0 <= r_s0 - w64;     r_sx <= r_sx - r_tx;
                                r_sy <= r_sy - r_ty;    r_sz <= r_sz - r_tz;
                                r_sxz <= r_sxz - r_txz; r_syz <= r_syz - r_tyz;
                                r_szz <= r_szz - r_tzz;
                                r_count <= r_count - CW'(1);
                            end
                            default: ;
                        endcase
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        case (r_step)
                            P_N1B:   r_fsx <= div_quo;
                            P_N2B:   r_fox <= div_quo;
                            P_N3B:   r_fsy <= div_quo;
                            default: r_foy <= div_quo;
                        endcase
                        if (r_step == P_N4B) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step  <= t_step'(r_step + 5'd1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (res_load) begin
                        r_out.hit_chi2     <= n_chi_sat ? 48'hFFFF_FFFF_FFFF : r_c[79:32];
                        r_out.slope_x_out  <= r_fsx;
                        r_out.offset_x_out <= r_fox;
                        r_out.slope_y_out  <= r_fsy;
                        r_out.offset_y_out <= r_foy;
                        r_out.count_out    <= cnt_ext[5:0];
                        r_out.status       <= r_reject ? STAT_REJECT :
                                              (r_degen ? STAT_DEGEN : STAT_OK);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HIT_LIMIT))
        else $error("hit count above maximum");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a hit");

    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_WAIT))
        else $error("product finished outside wait state");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DWAIT))
        else $error("quotient finished outside wait state");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && n_reject) |=> ($stable(r_count) && r_state == S_DONE))
        else $error("rejected operation changed the track");

endmodule
`default_nettype wire

// ----- tb/incremental_line_track_fit_unit_tb.sv -----
// Testbench for the incremental line track fit unit: random and directed hits, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module incremental_line_track_fit_unit_tb;
    import iltf_pkg::*;

    localparam int HIT_LIMIT = 63;
    localparam int CYCLE_LIMIT = 3000000;

    // Fit arithmetic: state of the line fit as the block should hold it.
    class fit_scoreboard;
        logic [23:0]  weight;
        logic [63:0]  s_w, s_x, s_y, s_z, s_xz, s_yz, s_zz;
        int unsigned  hits;
        logic [31:0]  slope_x, offset_x, slope_y, offset_y;
        t_out_item    pending[$];
        int           errors;

        function new();
            weight = WEIGHT_RESET;
            {s_w, s_x, s_y, s_z, s_xz, s_yz, s_zz} = '0;
            hits = 0;
            {slope_x, offset_x, slope_y, offset_y} = '0;
            errors = 0;
        endfunction

        // signed 64 x 64 product, exact in 128 bits
        function automatic logic signed [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
            logic signed [127:0] aa, bb;
            aa = {{64{a[63]}}, a};
            bb = {{64{b[63]}}, b};
            return aa * bb;
        endfunction

        // quotient to 16 fraction bits, toward zero, saturated to 32 bits
        function automatic logic [31:0] quotient_q16(logic signed [127:0] num,
                                                      logic signed [127:0] den);
            logic [143:0] n, q;
            logic [127:0] d;
            logic         neg;
            neg = num[127] != den[127];
            n = {(num[127] ? -num : num), 16'd0};
            d = den[127] ? -den : den;
            q = n / d;
            if (neg) begin
                if (q > 144'h8000_0000) return 32'h8000_0000;
                return -q[31:0];
            end
            if (q > 144'h7FFF_FFFF) return 32'h7FFF_FFFF;
            return q[31:0];
        endfunction

        function automatic bit refit();
            logic signed [127:0] den, ad;
            bit degen;
            den = wide_mul(s_zz, s_w) - wide_mul(s_z, s_z);
            ad = den[127] ? -den : den;
            degen = ad < DEN_EPS_RAW;
            if (degen) den = 128'sd1 <<< 32;
            slope_x  = quotient_q16(wide_mul(s_xz, s_w) - wide_mul(s_x, s_z), den);
            offset_x = quotient_q16(wide_mul(s_x, s_zz) - wide_mul(s_xz, s_z), den);
            slope_y  = quotient_q16(wide_mul(s_yz, s_w) - wide_mul(s_y, s_z), den);
            offset_y = quotient_q16(wide_mul(s_y, s_zz) - wide_mul(s_yz, s_z), den);
            return degen;
        endfunction

        function automatic logic [63:0] distance(logic [31:0] slope, logic [31:0] offset,
                                                 logic [31:0] z, logic [31:0] h);
            logic signed [63:0] prod, pred;
            prod = $signed({{32{slope[31]}}, slope}) * $signed({{32{z[31]}}, z});
            pred = (prod >>> 16) + $signed({{32{offset[31]}}, offset});
            pred = pred - $signed({{32{h[31]}}, h});
            return pred[63] ? -pred : pred;
        endfunction

        // Note one accepted hit beat and queue the result it must give.
        function void note_hit(t_in_item it);
            logic [63:0]  dx, dy, w, x, y, z, tx, ty, tz, txz, tyz, tzz;
            logic [127:0] e;
            logic [159:0] c;
            logic signed [127:0] p;
            t_out_item    r;
            bit           changed;
            dx = distance(slope_x, offset_x, it.hit_z, it.hit_x);
            dy = distance(slope_y, offset_y, it.hit_z, it.hit_y);
            e = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
            c = ({32'd0, e} * {136'd0, weight}) >> 32;
            r = '0;
            r.hit_chi2 = (c[159:48] != 0) ? 48'hFFFF_FFFF_FFFF : c[47:0];
            r.status = STAT_OK;
            w = {40'd0, weight};
            x = {{32{it.hit_x[31]}}, it.hit_x};
            y = {{32{it.hit_y[31]}}, it.hit_y};
            z = {{32{it.hit_z[31]}}, it.hit_z};
            tx = $signed(w * x) >>> 16;
            ty = $signed(w * y) >>> 16;
            tz = $signed(w * z) >>> 16;
            p = wide_mul(tz, x); txz = p[79:16];
            p = wide_mul(tz, y); tyz = p[79:16];
            p = wide_mul(tz, z); tzz = p[79:16];
            changed = 0;
            case (it.func)
                FUNC_START: begin
                    {s_w, s_x, s_y, s_z, s_xz, s_yz, s_zz} = {w, tx, ty, tz, txz, tyz, tzz};
                    hits = 1;
                    changed = 1;
                end
                FUNC_ADD: begin
                    if (hits >= HIT_LIMIT) r.status = STAT_REJECT;
                    else begin
                        s_w += w; s_x += tx; s_y += ty; s_z += tz;
                        s_xz += txz; s_yz += tyz; s_zz += tzz;
                        hits++;
                        changed = 1;
                    end
                end
                FUNC_REMOVE: begin
                    if (hits == 0) r.status = STAT_REJECT;
                    else begin
                        s_w -= w; s_x -= tx; s_y -= ty; s_z -= tz;
                        s_xz -= txz; s_yz -= tyz; s_zz -= tzz;
                        hits--;
                        changed = 1;
                    end
                end
                default: ;
            endcase
            if (changed && hits > 1 && refit()) r.status = STAT_DEGEN;
            r.slope_x_out = slope_x;
            r.offset_x_out = offset_x;
            r.slope_y_out = slope_y;
            r.offset_y_out = offset_y;
            r.count_out = hits[5:0];
            pending = {pending, r};
        endfunction

        // Check one accepted result beat against the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.hit_chi2 !== exp_r.hit_chi2) begin
                $error("hit_chi2 exp %h got %h", exp_r.hit_chi2, got.hit_chi2); errors++;
            end
            if (got.slope_x_out !== exp_r.slope_x_out) begin
                $error("slope_x_out exp %h got %h", exp_r.slope_x_out, got.slope_x_out);
                errors++;
            end
            if (got.offset_x_out !== exp_r.offset_x_out) begin
                $error("offset_x_out exp %h got %h", exp_r.offset_x_out, got.offset_x_out);
                errors++;
            end
            if (got.slope_y_out !== exp_r.slope_y_out) begin
                $error("slope_y_out exp %h got %h", exp_r.slope_y_out, got.slope_y_out);
                errors++;
            end
            if (got.offset_y_out !== exp_r.offset_y_out) begin
                $error("offset_y_out exp %h got %h", exp_r.offset_y_out, got.offset_y_out);
                errors++;
            end
            if (got.count_out !== exp_r.count_out) begin
                $error("count_out exp %0d got %0d", exp_r.count_out, got.count_out); errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_wdata = '0;

    fit_scoreboard track_model = new();
    int unsigned   cycle_count = 0;

    incremental_line_track_fit_unit #(.HIT_LIMIT(HIT_LIMIT)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // No gap half the time, else mostly a short one, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    // Result side: sample on the edge, check accepted beats, stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) track_model.check_result(o_out_data);
            i_out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one hit beat and hold it until the block takes it; with no gap,
    // valid stays high straight into the next beat.
    task automatic send_hit(t_func f, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_in_item it;
        int idle;
        idle = gap_length();
        if (idle != 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        it.func = f; it.hit_x = x; it.hit_y = y; it.hit_z = z;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        track_model.note_hit(it);
    endtask

    // Drop valid, let every expected result drain, then settle before a register write.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (track_model.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_weight(logic [23:0] wt);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= wt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        track_model.weight = wt;
    endtask

    // Coordinates: mostly modest values in mm, sometimes full-range noise.
    function automatic logic [31:0] coord();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        if (roll < 9) return $urandom();
        return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Build a track: start, a run of adds along a rough line, odd removes and queries.
    task automatic random_track(int n_hits);
        logic [31:0] sx, ox, sy, oy, z;
        int roll;
        sx = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
        sy = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
        ox = coord(); oy = coord();
        for (int k = 0; k < n_hits; k++) begin
            z = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            roll = $urandom_range(0, 99);
            if (k == 0 || roll < 3)
                send_hit(FUNC_START, ox + $urandom_range(0, 4095), oy, z);
            else if (roll < 75)
                send_hit(FUNC_ADD, ox + (($signed(sx) * $signed(z)) >>> 16)
                         + $urandom_range(0, 65535), oy + $urandom_range(0, 65535), z);
            else if (roll < 85) send_hit(FUNC_REMOVE, coord(), coord(), z);
            else if (roll < 95) send_hit(FUNC_QUERY, coord(), coord(), coord());
            else send_hit(t_func'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        int sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-track remove, query, extremes, repeated z (degenerate).
        send_hit(FUNC_REMOVE, 32'h0, 32'h0, 32'h0);
        send_hit(FUNC_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_hit(FUNC_START, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_hit(FUNC_ADD, 32'h0004_0000, 32'h0001_0000, 32'h0003_0000);
        send_hit(FUNC_ADD, 32'h0002_0000, 32'h0005_0000, 32'h0007_0000);
        send_hit(FUNC_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_hit(FUNC_REMOVE, 32'h0002_0000, 32'h0005_0000, 32'h0007_0000);
        send_hit(FUNC_REMOVE, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
        send_hit(FUNC_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_hit(FUNC_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_hit(FUNC_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
        send_hit(FUNC_REMOVE, 32'h0, 32'h0, 32'h0);
        send_hit(FUNC_REMOVE, 32'h0, 32'h0, 32'h0);
        send_hit(FUNC_REMOVE, 32'h0, 32'h0, 32'h0);
        send_hit(FUNC_REMOVE, 32'h0, 32'h0, 32'h0);
        // fill to the hit limit, then one add over it
        send_hit(FUNC_START, 32'h0, 32'h0, 32'h0);
        for (int k = 1; k <= HIT_LIMIT; k++)
            send_hit(FUNC_ADD, k << 16, -(k << 15), (k * 3) << 16);

        write_weight(24'd0);
        send_hit(FUNC_START, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_hit(FUNC_ADD, 32'h0002_0000, 32'h0003_0000, 32'h0005_0000);
        random_track(20);
        write_weight(24'hFF_FFFF);
        send_hit(FUNC_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        random_track(40);

        // Random phases with a new weight each time, including the smallest.
        sent = 0;
        while (sent < 760) begin
            case ($urandom_range(0, 3))
                0: write_weight(24'd1);
                1: write_weight(24'd65536);
                default: write_weight($urandom_range(0, 24'hFF_FFFF));
            endcase
            for (int t = 0; t < 3; t++) begin
                int n;
                n = $urandom_range(3, 70);
                random_track(n);
                sent += n;
            end
        end

        i_in_valid <= 1'b0;
        while (track_model.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (track_model.errors == 0 && track_model.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/iltf_pkg.sv
hdl/iltf_mul.sv
hdl/iltf_div.sv
hdl/incremental_line_track_fit_unit.sv
tb/incremental_line_track_fit_unit_tb.sv
